@@ sv/mldk_pkg.sv @@
// ----------------------------------------------------------------------------
// mldk_pkg: shared definitions for the magic/length deframer with keepalive
// Holds the message format constants, the keepalive word, the register
// indexes and the command passed from the front to the back of the block.
// ----------------------------------------------------------------------------
package mldk_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int HDR_BYTES         = 12;
    localparam int KA_LEN            = 12;
    localparam int MAGIC_BYTES       = 8;
    localparam int SIZE_BYTES        = 4;

    // Wide enough to hold any payload length and any payload position.
    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Register indexes of the configuration port.
    localparam logic [0:0] CFG_HEADER_MAGIC  = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT_LIMIT = 1'b1;

    localparam logic [7:0] TIMEOUT_LIMIT_RESET = 8'd5;

    // Input item kinds.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // One result item.
    typedef struct packed {
        logic       timed_out;
        logic       header_error;
        logic       alive_seen;
        logic       message_last;
        logic       byte_valid;
        logic [7:0] out_byte;
    } res_t;

    // Work for the back end: first flush_cnt bytes of the keepalive word
    // (held bytes are always a prefix of it), then optionally one result.
    typedef struct packed {
        logic [3:0] flush_cnt;
        logic       flush_last;
        logic       has_res;
        res_t       res;
    } cmd_t;

    // The keepalive word "WTC1KEEPALVE", first byte at index 0.
    function automatic logic [7:0] ka_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h57; // W
            4'd1:    b = 8'h54; // T
            4'd2:    b = 8'h43; // C
            4'd3:    b = 8'h31; // 1
            4'd4:    b = 8'h4B; // K
            4'd5:    b = 8'h45; // E
            4'd6:    b = 8'h45; // E
            4'd7:    b = 8'h50; // P
            4'd8:    b = 8'h41; // A
            4'd9:    b = 8'h4C; // L
            4'd10:   b = 8'h56; // V
            4'd11:   b = 8'h45; // E
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/mldk_front.sv @@
// ----------------------------------------------------------------------------
// mldk_front: header parser and keepalive classifier
// Tracks the parse phase, checks magic and size, matches the payload against
// the keepalive word, counts ticks and turns each item into a back-end command.
// ----------------------------------------------------------------------------
module mldk_front
    import mldk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        in_accept,
    input  logic        in_cmd,
    input  logic [7:0]  in_byte,
    output logic        push,
    output cmd_t        push_cmd
);

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'b001,
        PH_SIZE    = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [23:0]        size_lo_reg, size_lo_next;
    logic [POS_W-1:0]   plen_reg, plen_next;
    logic               match_reg, match_next;
    logic               alive_reg, alive_next;
    logic [7:0]         missed_reg, missed_next;
    logic [63:0]        magic_reg;
    logic [7:0]         limit_reg;

    logic [POS_W:0]     pos_inc;
    logic               last;
    logic [2:0]         mag_idx;
    logic [7:0]         want;
    logic [31:0]        size_full;
    logic [7:0]         missed_inc;
    cmd_t               cmd;

    assign pos_inc   = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};
    assign last      = (pos_inc >= {1'b0, plen_reg});
    assign mag_idx   = 3'd7 - pos_reg[2:0];
    assign want      = magic_reg[{mag_idx, 3'b000} +: 8];
    assign size_full = {in_byte, size_lo_reg};
    assign missed_inc = (missed_reg == 8'hFF) ? missed_reg : missed_reg + 8'd1;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        size_lo_next = size_lo_reg;
        plen_next    = plen_reg;
        match_next   = match_reg;
        alive_next   = alive_reg;
        missed_next  = missed_reg;
        cmd          = '0;

        if (in_cmd == CMD_TICK) begin
            if (alive_reg) begin
                alive_next  = 1'b0;
                missed_next = 8'd0;
            end else begin
                missed_next = missed_inc;
                if (missed_inc >= limit_reg) begin
                    // Timeout drops the parser back to its reset state.
                    phase_next            = PH_MAGIC;
                    pos_next              = '0;
                    match_next            = 1'b1;
                    alive_next            = 1'b0;
                    missed_next           = 8'd0;
                    cmd.has_res           = 1'b1;
                    cmd.res.timed_out     = 1'b1;
                end
            end
        end else begin
            case (phase_reg)
                PH_SIZE: begin
                    if (pos_reg[1:0] == 2'd0) begin
                        size_lo_next = {16'd0, in_byte};
                    end else if (pos_reg[1:0] != 2'd3) begin
                        size_lo_next[{pos_reg[1:0], 3'b000} +: 8] = in_byte;
                    end
                    if (pos_reg[1:0] != 2'd3) begin
                        pos_next = {{(POS_W-2){1'b0}}, pos_reg[1:0] + 2'd1};
                    end else if (size_full < 32'(HDR_BYTES) ||
                                 size_full > 32'(MAX_MESSAGE_BYTES)) begin
                        phase_next           = PH_MAGIC;
                        pos_next             = '0;
                        match_next           = 1'b1;
                        cmd.has_res          = 1'b1;
                        cmd.res.header_error = 1'b1;
                    end else if (size_full == 32'(HDR_BYTES)) begin
                        phase_next           = PH_MAGIC;
                        pos_next             = '0;
                        match_next           = 1'b1;
                        cmd.has_res          = 1'b1;
                        cmd.res.message_last = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                        pos_next   = '0;
                        match_next = 1'b1;
                        plen_next  = size_full[POS_W-1:0] - POS_W'(HDR_BYTES);
                    end
                end
                PH_PAYLOAD: begin
                    if (match_reg) begin
                        if (pos_reg >= POS_W'(KA_LEN)) begin
                            if (last) begin
                                alive_next         = 1'b1;
                                cmd.has_res        = 1'b1;
                                cmd.res.alive_seen = 1'b1;
                            end
                        end else if (in_byte == ka_byte(pos_reg[3:0])) begin
                            if (pos_reg[3:0] == 4'(KA_LEN - 1)) begin
                                if (last) begin
                                    alive_next         = 1'b1;
                                    cmd.has_res        = 1'b1;
                                    cmd.res.alive_seen = 1'b1;
                                end
                            end else if (last) begin
                                // Message ended on a keepalive prefix: deliver it.
                                cmd.flush_cnt  = pos_reg[3:0] + 4'd1;
                                cmd.flush_last = 1'b1;
                            end
                        end else begin
                            match_next           = 1'b0;
                            cmd.flush_cnt        = pos_reg[3:0];
                            cmd.has_res          = 1'b1;
                            cmd.res.byte_valid   = 1'b1;
                            cmd.res.out_byte     = in_byte;
                            cmd.res.message_last = last;
                        end
                    end else begin
                        cmd.has_res          = 1'b1;
                        cmd.res.byte_valid   = 1'b1;
                        cmd.res.out_byte     = in_byte;
                        cmd.res.message_last = last;
                    end
                    if (last) begin
                        phase_next = PH_MAGIC;
                        pos_next   = '0;
                        match_next = 1'b1;
                    end else begin
                        pos_next = pos_inc[POS_W-1:0];
                    end
                end
                default: begin
                    if (in_byte != want) begin
                        phase_next           = PH_MAGIC;
                        pos_next             = '0;
                        match_next           = 1'b1;
                        cmd.has_res          = 1'b1;
                        cmd.res.header_error = 1'b1;
                    end else if (pos_reg[2:0] == 3'd7) begin
                        phase_next = PH_SIZE;
                        pos_next   = '0;
                    end else begin
                        phase_next = PH_MAGIC;
                        pos_next   = {{(POS_W-3){1'b0}}, pos_reg[2:0] + 3'd1};
                    end
                end
            endcase
        end
    end

    assign push     = in_accept && (cmd.has_res || cmd.flush_cnt != 4'd0);
    assign push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MAGIC;
            pos_reg     <= '0;
            size_lo_reg <= '0;
            plen_reg    <= '0;
            match_reg   <= 1'b1;
            alive_reg   <= 1'b0;
            missed_reg  <= 8'd0;
            magic_reg   <= 64'd0;
            limit_reg   <= TIMEOUT_LIMIT_RESET;
        end else begin
            if (in_accept) begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                size_lo_reg <= size_lo_next;
                plen_reg    <= plen_next;
                match_reg   <= match_next;
                alive_reg   <= alive_next;
                missed_reg  <= missed_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HEADER_MAGIC:  magic_reg <= cfg_wdata;
                    CFG_TIMEOUT_LIMIT: limit_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ sv/mldk_fifo.sv @@
// ----------------------------------------------------------------------------
// mldk_fifo: short command queue between front and back
// Four entries, so the parser keeps taking items while the back end expands
// a flush of held bytes.
// ----------------------------------------------------------------------------
module mldk_fifo
    import mldk_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    cmd_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (FIFO_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/mldk_back.sv @@
// ----------------------------------------------------------------------------
// mldk_back: result sequencer
// Expands each command into result items in the output register, one per
// cycle unless stalled: held keepalive prefix bytes first, then any result.
// ----------------------------------------------------------------------------
module mldk_back
    import mldk_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  empty,
    input  cmd_t  head,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_res
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg;
    res_t       res_reg;
    res_t       res_next;
    logic       load;
    logic       take;

    assign load = !valid_reg || out_ready;
    assign take = load && !empty;

    always_comb begin
        idx_next = idx_reg;
        pop      = 1'b0;
        res_next = '0;
        if (idx_reg < head.flush_cnt) begin
            res_next.byte_valid   = 1'b1;
            res_next.out_byte     = ka_byte(idx_reg);
            res_next.message_last = head.flush_last &&
                                    (idx_reg + 4'd1 == head.flush_cnt);
            if ((idx_reg + 4'd1 == head.flush_cnt) && !head.has_res) begin
                pop      = take;
                idx_next = 4'd0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end else begin
            res_next = head.res;
            pop      = take;
            idx_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                idx_reg <= idx_next;
            end
            if (load) begin
                valid_reg <= !empty;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ sv/magic_length_deframer_keepalive.sv @@
// ----------------------------------------------------------------------------
// magic_length_deframer_keepalive: per-connection receive deframer
// A result item passes through the command queue and the output register
// to the m_ side. One input item per cycle while the queue is not full; an
// item releasing n held keepalive bytes yields those n bytes before any result.
// Reset (aresetn low, synchronous) clears the parser, queue and output
// register; header_magic resets to 0 and timeout_limit to 5.
// ----------------------------------------------------------------------------
module magic_length_deframer_keepalive
    import mldk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port; index 0 is header_magic, index 1 timeout_limit.
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_wdata,

    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic [0:0]  s_tuser,     // [0] cmd

    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] out_byte
    output logic        m_tlast,     // message_last
    output logic [3:0]  m_tuser      // [0] byte_valid, [1] alive_seen,
                                     // [2] header_error, [3] timed_out
);

    // The front end parses every item in the cycle it is accepted and queues
    // a command whenever the item causes at least one result. The back end
    // drains that queue into a registered output stage, so a stalled m_ side
    // only stops input once the four-entry queue is full.

    logic in_accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic full;
    logic empty;
    cmd_t head;
    res_t out_res;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    mldk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_cmd    (s_tuser[0]),
        .in_byte   (s_tdata),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mldk_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    mldk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // The output byte is already zero whenever byte_valid is low.
    assign m_tdata = out_res.out_byte;
    assign m_tlast = out_res.message_last;
    assign m_tuser = {out_res.timed_out, out_res.header_error,
                      out_res.alive_seen, out_res.byte_valid};

endmodule
